// ===== design/hsv_color_twist_pixel_macros.svh =====
// assertion macros used by the top design file, hsv_color_twist_pixel
`ifndef HSV_COLOR_TWIST_PIXEL_MACROS_SVH
`define HSV_COLOR_TWIST_PIXEL_MACROS_SVH
`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define HCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked on every clock edge outside reset
`define HCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define HCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define HCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/hct_pkg.sv =====
package hct_pkg;

    localparam int COL_LIMIT_DEF = 4096;
    localparam int HUE_FULL      = 23040;
    localparam int HUE_SECTOR    = 3840;
    localparam int SAT_ONE       = 65536;
    localparam int DIV_BITS      = 24;
    localparam int DIV_DEN_BITS  = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROI_COLUMNS       = 3'd0,
        REG_ROI_ROWS          = 3'd1,
        REG_CONTRAST_GAIN     = 3'd2,
        REG_BRIGHTNESS_OFFSET = 3'd3,
        REG_HUE_SHIFT         = 3'd4,
        REG_SATURATION_GAIN   = 3'd5,
        REG_SIGNED_SAMPLES    = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } t_maxsel;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pixel_out;

endpackage

// ===== design/hct_div.sv =====
module hct_div #(
    parameter int NW = 24,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    // one quotient bit per stage, restoring form
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_den [NW];

    for (genvar j = 0; j < NW; j++) begin : g_stage
        logic [DW-1:0] prev_rem;
        logic [NW-1:0] prev_num;
        logic [NW-1:0] prev_quo;
        logic [DW-1:0] prev_den;
        logic [DW:0]   trial;
        logic [DW:0]   sub;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [NW-1:0] n_quo;

        if (j == 0) begin : g_first
            assign prev_rem = '0;
            assign prev_num = i_num;
            assign prev_quo = '0;
            assign prev_den = i_den;
        end else begin : g_next
            assign prev_rem = r_rem[j-1];
            assign prev_num = r_num[j-1];
            assign prev_quo = r_quo[j-1];
            assign prev_den = r_den[j-1];
        end

        always_comb begin
            trial = {prev_rem, prev_num[NW-1-j]};
            sub   = trial - {1'b0, prev_den};
            ge    = trial >= {1'b0, prev_den};
            n_rem = ge ? sub[DW-1:0] : trial[DW-1:0];
            n_quo = prev_quo;
            n_quo[NW-1-j] = ge;
        end

        always_ff @(posedge i_clk) begin
            r_rem[j] <= n_rem;
            r_num[j] <= prev_num;
            r_quo[j] <= n_quo;
            r_den[j] <= prev_den;
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

// ===== design/hct_scale.sv =====
module hct_scale (
    input  logic        i_clk,
    input  logic [7:0]  i_value,
    input  logic [16:0] i_sat,
    input  logic [11:0] i_frac,
    output logic [7:0]  o_value
);
    import hct_pkg::*;

    // full scale of sat * frac, 2^16 * 3840 = 2^24 * 15
    localparam logic [27:0] DEN = 28'(SAT_ONE * HUE_SECTOR);
    // floor(y / 15) for y below 2^16
    localparam logic [15:0] RECIP15 = 16'd34953;

    logic [27:0] r_x;
    logic [7:0]  r_m;
    logic [11:0] r_y;
    logic [7:0]  r_q;
    logic [28:0] x_full;
    logic [35:0] prod;
    logic [27:0] q_full;

    // stage a: saturation times fraction
    assign x_full = 29'(i_sat) * 29'(i_frac);
    always_ff @(posedge i_clk) begin
        r_x <= x_full[27:0];
        r_m <= i_value;
    end

    // stage b: value times complement, drop the 2^24 part of the divisor
    assign prod = 36'(r_m) * 36'(DEN - r_x);
    always_ff @(posedge i_clk) begin
        r_y <= prod[35:24];
    end

    // stage c: divide by 15 through the reciprocal
    assign q_full = 28'(r_y) * 28'(RECIP15);
    always_ff @(posedge i_clk) begin
        r_q <= q_full[26:19];
    end

    assign o_value = r_q;

endmodule

// ===== design/hsv_color_twist_pixel.sv =====
// throughput: one pixel per cycle, busy never rises; the 24-stage dividers set the depth
// reset: synchronous active low, clears valid bits and restores register defaults
// the result strobe cannot be stalled by the receiver
module hsv_color_twist_pixel #(
    parameter int COL_LIMIT = hct_pkg::COL_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  hct_pkg::t_pixel_in            i_pixel,
    output logic                          o_valid,
    output hct_pkg::t_pixel_out           o_pixel,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hct_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [hct_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import hct_pkg::*;
    `include "hsv_color_twist_pixel_macros.svh"

    localparam int LAT = DIV_BITS + 9;

    typedef struct packed {
        logic [23:0] raw;
        logic        in_roi;
        logic [7:0]  mx;
        t_maxsel     sel;
        logic        dneg;
        logic        hsok;
    } t_side;

    // sector 0..6, or 7 for any sector outside that range
    typedef struct packed {
        logic [23:0] raw;
        logic        in_roi;
        logic [2:0]  k;
    } t_side2;

    // configuration registers
    logic [23:0]        r_roi_columns;
    logic [23:0]        r_roi_rows;
    logic signed [15:0] r_contrast_gain;
    logic signed [12:0] r_brightness_offset;
    logic signed [15:0] r_hue_shift;
    logic [15:0]        r_saturation_gain;
    logic               r_signed_samples;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roi_columns       <= 24'hFFF000;
            r_roi_rows          <= 24'hFFF000;
            r_contrast_gain     <= 16'sd4096;
            r_brightness_offset <= '0;
            r_hue_shift         <= '0;
            r_saturation_gain   <= 16'd4096;
            r_signed_samples    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROI_COLUMNS:       r_roi_columns       <= i_cfg_data;
                REG_ROI_ROWS:          r_roi_rows          <= i_cfg_data;
                REG_CONTRAST_GAIN:     r_contrast_gain     <= i_cfg_data[15:0];
                REG_BRIGHTNESS_OFFSET: r_brightness_offset <= i_cfg_data[12:0];
                REG_HUE_SHIFT:         r_hue_shift         <= i_cfg_data[15:0];
                REG_SATURATION_GAIN:   r_saturation_gain   <= i_cfg_data[15:0];
                REG_SIGNED_SAMPLES:    r_signed_samples    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [7:0] flip;
    assign flip = r_signed_samples ? 8'h80 : 8'h00;

    // stage 1: region test and sign offset
    logic        accept;
    logic        n1_in_roi;
    logic        r1_valid;
    logic [23:0] r1_raw;
    logic [7:0]  r1_r, r1_g, r1_b;
    logic        r1_in_roi;

    assign accept = start && !busy;
    assign n1_in_roi = i_pixel.column >= r_roi_columns[11:0]
                    && i_pixel.column <= r_roi_columns[23:12]
                    && i_pixel.row >= r_roi_rows[11:0]
                    && i_pixel.row <= r_roi_rows[23:12]
                    && 32'(i_pixel.column) < 32'(COL_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else          r1_valid <= accept;
    end
    always_ff @(posedge i_clk) begin
        r1_raw    <= {i_pixel.red_in, i_pixel.green_in, i_pixel.blue_in};
        r1_r      <= i_pixel.red_in ^ flip;
        r1_g      <= i_pixel.green_in ^ flip;
        r1_b      <= i_pixel.blue_in ^ flip;
        r1_in_roi <= n1_in_roi;
    end

    // stage 2: max, min, difference and divider operands
    logic [7:0]        mx, mn, diff, dmag;
    t_maxsel           sel;
    logic signed [8:0] d;
    logic              hsok;
    logic [19:0]       nhue;
    logic [DIV_BITS-1:0] r2_nhue, r2_nsat;
    logic [DIV_DEN_BITS-1:0] r2_dhue, r2_dsat;
    logic              r2_valid;
    t_side             r2_side;

    always_comb begin
        mx = r1_r;
        mn = r1_r;
        if (r1_g > mx) mx = r1_g;
        if (r1_b > mx) mx = r1_b;
        if (r1_g < mn) mn = r1_g;
        if (r1_b < mn) mn = r1_b;
        diff = mx - mn;
        if (mx == r1_r) begin
            sel = MAX_RED;
            d   = $signed({1'b0, r1_g}) - $signed({1'b0, r1_b});
        end else if (mx == r1_g) begin
            sel = MAX_GREEN;
            d   = $signed({1'b0, r1_b}) - $signed({1'b0, r1_r});
        end else begin
            sel = MAX_BLUE;
            d   = $signed({1'b0, r1_r}) - $signed({1'b0, r1_g});
        end
        dmag = d[8] ? 8'(-d) : d[7:0];
        hsok = (mx != 8'd0) && (diff != 8'd0);
        nhue = 20'(dmag) * 20'(HUE_SECTOR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else          r2_valid <= r1_valid;
    end
    always_ff @(posedge i_clk) begin
        r2_nhue <= DIV_BITS'(nhue);
        r2_nsat <= DIV_BITS'({diff, 16'h0000});
        r2_dhue <= hsok ? diff : 8'd1;
        r2_dsat <= hsok ? mx : 8'd1;
        r2_side <= '{raw: r1_raw, in_roi: r1_in_roi, mx: mx, sel: sel,
                     dneg: d[8], hsok: hsok};
    end

    // dividers for hue term and saturation
    logic [DIV_BITS-1:0] q_hue, q_sat;

    hct_div #(.NW(DIV_BITS), .DW(DIV_DEN_BITS)) u_div_hue (
        .i_clk (i_clk),
        .i_num (r2_nhue),
        .i_den (r2_dhue),
        .o_quo (q_hue)
    );

    hct_div #(.NW(DIV_BITS), .DW(DIV_DEN_BITS)) u_div_sat (
        .i_clk (i_clk),
        .i_num (r2_nsat),
        .i_den (r2_dsat),
        .o_quo (q_sat)
    );

    // side data follows the dividers
    t_side r_dside [DIV_BITS];
    logic  r_dvalid [DIV_BITS];

    for (genvar j = 0; j < DIV_BITS; j++) begin : g_dline
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dvalid[j] <= 1'b0;
            else          r_dvalid[j] <= (j == 0) ? r2_valid : r_dvalid[(j == 0) ? 0 : j-1];
        end
        always_ff @(posedge i_clk) begin
            r_dside[j] <= (j == 0) ? r2_side : r_dside[(j == 0) ? 0 : j-1];
        end
    end

    // stage 3: hue with shift and wrap, saturation product
    t_side              dsd;
    logic signed [17:0] term, h0, h1, n3_hue;
    logic [16:0]        sat;
    logic               r3_valid;
    logic signed [17:0] r3_hue;
    logic [32:0]        r3_sprod;
    t_side              r3_side;

    assign dsd = r_dside[DIV_BITS-1];

    always_comb begin
        term = dsd.dneg ? -$signed({6'b0, q_hue[11:0]}) : $signed({6'b0, q_hue[11:0]});
        case (dsd.sel)
            MAX_RED:   h0 = (term < 0) ? term + 18'sd23040 : term;
            MAX_GREEN: h0 = 18'sd7680 + term;
            default:   h0 = 18'sd15360 + term;
        endcase
        if (!dsd.hsok) h0 = '0;
        h1 = h0 + 18'(r_hue_shift);
        if (h1 > 18'sd23040)   n3_hue = h1 - 18'sd23040;
        else if (h1 < 18'sd0)  n3_hue = h1 + 18'sd23040;
        else                   n3_hue = h1;
        sat = dsd.hsok ? q_sat[16:0] : 17'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_valid <= 1'b0;
        else          r3_valid <= r_dvalid[DIV_BITS-1];
    end
    always_ff @(posedge i_clk) begin
        r3_hue   <= n3_hue;
        r3_sprod <= 33'(sat) * 33'(r_saturation_gain);
        r3_side  <= dsd;
    end

    // stage 4: sector and fraction, saturation clamp
    // a single wrap leaves the hue in -9728..32767, so the sector runs -3..8
    logic signed [4:0]  n4_k;
    logic signed [17:0] kbase;
    logic signed [17:0] fdiff;
    logic [2:0]         n4_sec;
    logic [20:0] sh;
    logic        r4_valid;
    logic [2:0]  r4_k;
    logic [11:0] r4_f;
    logic [16:0] r4_sat;
    logic [7:0]  r4_mx;
    t_side2      r4_side;

    always_comb begin
        n4_k = -5'sd3;
        for (int j = -2; j <= 8; j++) begin
            if (r3_hue >= $signed(18'(j * HUE_SECTOR))) n4_k = n4_k + 5'sd1;
        end
        kbase  = $signed(18'(n4_k)) * $signed(18'(HUE_SECTOR));
        fdiff  = r3_hue - kbase;
        n4_sec = (n4_k >= 5'sd0 && n4_k <= 5'sd6) ? n4_k[2:0] : 3'd7;
        sh     = r3_sprod[32:12];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_valid <= 1'b0;
        else          r4_valid <= r3_valid;
    end
    always_ff @(posedge i_clk) begin
        r4_k    <= n4_sec;
        r4_f    <= fdiff[11:0];
        r4_sat  <= (sh > 21'(SAT_ONE)) ? 17'(SAT_ONE) : sh[16:0];
        r4_mx   <= r3_side.mx;
        r4_side <= '{raw: r3_side.raw, in_roi: r3_side.in_roi, k: n4_sec};
    end

    // stages 5 to 7: p, q and t
    logic [7:0] pv, qv, tv;

    hct_scale u_scale_p (
        .i_clk   (i_clk),
        .i_value (r4_mx),
        .i_sat   (r4_sat),
        .i_frac  (12'(HUE_SECTOR)),
        .o_value (pv)
    );

    hct_scale u_scale_q (
        .i_clk   (i_clk),
        .i_value (r4_mx),
        .i_sat   (r4_sat),
        .i_frac  (r4_f),
        .o_value (qv)
    );

    hct_scale u_scale_t (
        .i_clk   (i_clk),
        .i_value (r4_mx),
        .i_sat   (r4_sat),
        .i_frac  (12'(HUE_SECTOR) - r4_f),
        .o_value (tv)
    );

    t_side2     r_sside [3];
    logic [7:0] r_smx [3];
    logic       r_svalid [3];

    for (genvar j = 0; j < 3; j++) begin : g_sline
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_svalid[j] <= 1'b0;
            else          r_svalid[j] <= (j == 0) ? r4_valid : r_svalid[(j == 0) ? 0 : j-1];
        end
        always_ff @(posedge i_clk) begin
            r_sside[j] <= (j == 0) ? r4_side : r_sside[(j == 0) ? 0 : j-1];
            r_smx[j]   <= (j == 0) ? r4_mx : r_smx[(j == 0) ? 0 : j-1];
        end
    end

    // stage 8: sector selection and contrast products
    logic [7:0]         c0, c1, c2, vv;
    logic signed [25:0] boff;
    logic               r8_valid;
    logic signed [25:0] r8_sum0, r8_sum1, r8_sum2;
    logic [23:0]        r8_raw;
    logic               r8_in_roi;

    assign vv = r_smx[2];

    always_comb begin
        case (r_sside[2].k)
            3'd0, 3'd6: begin c0 = vv; c1 = tv; c2 = pv; end
            3'd1:       begin c0 = qv; c1 = vv; c2 = pv; end
            3'd2:       begin c0 = pv; c1 = vv; c2 = tv; end
            3'd3:       begin c0 = pv; c1 = qv; c2 = vv; end
            3'd4:       begin c0 = tv; c1 = pv; c2 = vv; end
            default:    begin c0 = vv; c1 = pv; c2 = qv; end
        endcase
        boff = 26'(r_brightness_offset) <<< 8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_valid <= 1'b0;
        else          r8_valid <= r_svalid[2];
    end
    always_ff @(posedge i_clk) begin
        r8_sum0   <= 26'(r_contrast_gain) * 26'($signed({1'b0, c0})) + boff;
        r8_sum1   <= 26'(r_contrast_gain) * 26'($signed({1'b0, c1})) + boff;
        r8_sum2   <= 26'(r_contrast_gain) * 26'($signed({1'b0, c2})) + boff;
        r8_raw    <= r_sside[2].raw;
        r8_in_roi <= r_sside[2].in_roi;
    end

    // stage 9: clamp, sign offset and region bypass
    function automatic logic [7:0] clamp_byte(input logic signed [25:0] sum);
        logic signed [25:0] sc;
        sc = sum >>> 12;
        if (sum < 0)                 return 8'd0;
        else if (sc > 26'sd255)      return 8'd255;
        else                         return sc[7:0];
    endfunction

    logic       r_valid;
    t_pixel_out r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= r8_valid;
    end
    always_ff @(posedge i_clk) begin
        if (r8_in_roi) begin
            r_pixel.red_out   <= clamp_byte(r8_sum0) ^ flip;
            r_pixel.green_out <= clamp_byte(r8_sum1) ^ flip;
            r_pixel.blue_out  <= clamp_byte(r8_sum2) ^ flip;
        end else begin
            r_pixel <= r8_raw;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

    // checks
    `HCT_ASSERT_IMP(a_out_latency, i_clk, i_rst_n, o_valid, $past(accept, LAT), "result without item")
    `HCT_ASSERT_IMP(a_hue_range, i_clk, i_rst_n, r3_valid, (r3_hue >= -18'sd9728) && (r3_hue <= 18'sd32767), "hue out of range")
    `HCT_ASSERT_IMP(a_sat_clamp, i_clk, i_rst_n, r4_valid, r4_sat <= 17'(SAT_ONE), "saturation above one")
    `HCT_ASSERT(a_frac, i_clk, i_rst_n, !r4_valid || r4_f < 12'(HUE_SECTOR), "fraction beyond one sector")

endmodule
